@@ rtl/core/qvr_pkg.sv @@
// Shared types and constants for the quaternion vector rotation block.
// Holds the request and response payload structs and register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qvr_pkg;

  localparam int VEC_WIDTH  = 16;
  localparam int FRAC_BITS  = 14;
  localparam int QUAT_WIDTH = FRAC_BITS + 2;

  typedef enum logic [1:0] {
    REG_QUAT_W = 2'd0,
    REG_QUAT_X = 2'd1,
    REG_QUAT_Y = 2'd2,
    REG_QUAT_Z = 2'd3
  } qvr_reg_t;

  typedef struct packed {
    logic signed [VEC_WIDTH-1:0] vec_x;
    logic signed [VEC_WIDTH-1:0] vec_y;
    logic signed [VEC_WIDTH-1:0] vec_z;
    logic                        undo_rotation;
  } qvr_req_t;

  typedef struct packed {
    logic signed [VEC_WIDTH-1:0] out_x;
    logic signed [VEC_WIDTH-1:0] out_y;
    logic signed [VEC_WIDTH-1:0] out_z;
    logic                        clipped;
  } qvr_rsp_t;

endpackage

`default_nettype wire

@@ rtl/core/quaternion_vector_rotate.sv @@
// Top level of the quaternion vector rotation block: five-stage pipeline.
// Depends on qvr_pkg for payload structs, widths and register indexes.
`timescale 1ns / 1ps
`default_nettype none

// Rotates each request vector p by the stored quaternion q, giving q*(0,p)*conj(q),
// or conj(q)*(0,p)*q when undo_rotation is set. One request is taken every clock
// cycle unless stalled; a request passes the stages in order: first multiply level,
// first Hamilton sums, second multiply level, second Hamilton sums, round and
// saturate. Each stage stalls only when it is full and the one after it cannot
// move, so bubbles are squeezed out under backpressure. The user must write the
// quaternion (Q2.14) through the cfg port only while the pipeline is empty, which
// the block does not enforce. It resets to the identity. q is not normalised; a
// non-unit q scales the result by |q|^2 and clipped flags any saturated component.
module quaternion_vector_rotate
  import qvr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire qvr_reg_t              cfg_index,
  input  wire logic [QUAT_WIDTH-1:0] cfg_data,
  input  wire logic                  req_valid,
  output      logic                  req_stall,
  input  wire qvr_req_t              req,
  output      logic                  rsp_valid,
  input  wire logic                  rsp_stall,
  output      qvr_rsp_t              rsp
);

  localparam int NSTG = 5;
  localparam int PW   = VEC_WIDTH + QUAT_WIDTH;  // first-level product
  localparam int TW   = PW + 2;                  // first Hamilton sum
  localparam int MW   = TW + QUAT_WIDTH;         // second-level product
  localparam int SW   = MW + 3;                  // second Hamilton sum
  localparam int SH   = 2 * FRAC_BITS;

  localparam logic signed [VEC_WIDTH-1:0] VMAX = {1'b0, {(VEC_WIDTH-1){1'b1}}};
  localparam logic signed [VEC_WIDTH-1:0] VMIN = {1'b1, {(VEC_WIDTH-1){1'b0}}};
  localparam logic signed [SW-1:0] RND  = SW'(1) <<< (SH - 1);
  localparam logic signed [SW-1:0] SMAX = SW'(VMAX);
  localparam logic signed [SW-1:0] SMIN = SW'(VMIN);

  // orientation registers
  logic signed [QUAT_WIDTH-1:0] quat_w;
  logic signed [QUAT_WIDTH-1:0] quat_v [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      quat_w    <= QUAT_WIDTH'(1) <<< FRAC_BITS;
      quat_v[0] <= '0;
      quat_v[1] <= '0;
      quat_v[2] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_QUAT_W: quat_w    <= cfg_data;
        REG_QUAT_X: quat_v[0] <= cfg_data;
        REG_QUAT_Y: quat_v[1] <= cfg_data;
        REG_QUAT_Z: quat_v[2] <= cfg_data;
        default:    quat_w    <= quat_w;
      endcase
    end
  end

  // pipeline control: a stage loads when empty or when the next one moves
  logic [NSTG-1:0] vld;
  logic [NSTG:0]   rdy;

  always_comb begin
    rdy[NSTG] = !rsp_stall;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= req_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign req_stall = !rdy[0];
  assign rsp_valid = vld[NSTG-1];

  // stage 1: q components times p
  logic signed [VEC_WIDTH-1:0] p [3];
  logic signed [PW-1:0]        s1_wp [3];
  logic signed [PW-1:0]        s1_qp [3][3];  // [j][i] = q_j * p_i
  logic                        s1_undo;

  assign p[0] = req.vec_x;
  assign p[1] = req.vec_y;
  assign p[2] = req.vec_z;

  always_ff @(posedge clk) begin
    if (rdy[0] && req_valid) begin
      s1_undo <= req.undo_rotation;
      for (int i = 0; i < 3; i++) begin
        s1_wp[i] <= PW'(quat_w) * PW'(p[i]);
        for (int j = 0; j < 3; j++) begin
          s1_qp[j][i] <= PW'(quat_v[j]) * PW'(p[i]);
        end
      end
    end
  end

  // stage 2: first Hamilton product, t = q' * (0,p)
  logic signed [TW-1:0] dot_s;
  logic signed [TW-1:0] crs [3];
  logic signed [TW-1:0] t0_next;
  logic signed [TW-1:0] tv_next [3];
  logic signed [TW-1:0] s2_t0;
  logic signed [TW-1:0] s2_tv [3];
  logic                 s2_undo;

  always_comb begin
    dot_s  = TW'(s1_qp[0][0]) + TW'(s1_qp[1][1]) + TW'(s1_qp[2][2]);
    crs[0] = TW'(s1_qp[1][2]) - TW'(s1_qp[2][1]);
    crs[1] = TW'(s1_qp[2][0]) - TW'(s1_qp[0][2]);
    crs[2] = TW'(s1_qp[0][1]) - TW'(s1_qp[1][0]);
    // conjugate on the left flips the sign of every vector-part term
    t0_next = s1_undo ? dot_s : -dot_s;
    for (int i = 0; i < 3; i++) begin
      tv_next[i] = TW'(s1_wp[i]) + (s1_undo ? -crs[i] : crs[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1] && vld[0]) begin
      s2_undo <= s1_undo;
      s2_t0   <= t0_next;
      s2_tv   <= tv_next;
    end
  end

  // stage 3: t components times q
  logic signed [MW-1:0] s3_wt [3];
  logic signed [MW-1:0] s3_tq [3];
  logic signed [MW-1:0] s3_vq [3][3];  // [i][j] = t_i * q_j, diagonal unused
  logic                 s3_undo;

  always_ff @(posedge clk) begin
    if (rdy[2] && vld[1]) begin
      s3_undo <= s2_undo;
      for (int i = 0; i < 3; i++) begin
        s3_wt[i] <= MW'(quat_w) * MW'(s2_tv[i]);
        s3_tq[i] <= MW'(s2_t0) * MW'(quat_v[i]);
        for (int j = 0; j < 3; j++) begin
          if (i != j) begin
            s3_vq[i][j] <= MW'(s2_tv[i]) * MW'(quat_v[j]);
          end
        end
      end
    end
  end

  // stage 4: vector part of the second Hamilton product
  logic signed [SW-1:0] xv [3];
  logic signed [SW-1:0] dv [3];
  logic signed [SW-1:0] r_next [3];
  logic signed [SW-1:0] s4_r [3];

  always_comb begin
    xv[0] = SW'(s3_vq[1][2]) - SW'(s3_vq[2][1]);
    xv[1] = SW'(s3_vq[2][0]) - SW'(s3_vq[0][2]);
    xv[2] = SW'(s3_vq[0][1]) - SW'(s3_vq[1][0]);
    for (int i = 0; i < 3; i++) begin
      dv[i]     = SW'(s3_tq[i]) + xv[i];
      r_next[i] = SW'(s3_wt[i]) + (s3_undo ? dv[i] : -dv[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3] && vld[2]) begin
      s4_r <= r_next;
    end
  end

  // stage 5: round half up, drop the fraction, saturate
  logic signed [SW-1:0]        rsh [3];
  logic signed [VEC_WIDTH-1:0] sat [3];
  logic [2:0]                  clip;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rsh[i] = (s4_r[i] + RND) >>> SH;
      if (rsh[i] > SMAX) begin
        sat[i]  = VMAX;
        clip[i] = 1'b1;
      end else if (rsh[i] < SMIN) begin
        sat[i]  = VMIN;
        clip[i] = 1'b1;
      end else begin
        sat[i]  = rsh[i][VEC_WIDTH-1:0];
        clip[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4] && vld[3]) begin
      rsp.out_x   <= sat[0];
      rsp.out_y   <= sat[1];
      rsp.out_z   <= sat[2];
      rsp.clipped <= |clip;
    end
  end

`ifndef SYNTHESIS
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> vld[0])
    else $error("accepted request did not enter stage 1");

  a_no_stall_with_room: assert property (@(posedge clk) disable iff (rst)
    !(&vld) |-> !req_stall)
    else $error("request stalled while the pipeline has an empty stage");

  a_mid_hold: assert property (@(posedge clk) disable iff (rst)
    vld[2] && !rdy[3] |=> vld[2])
    else $error("stage 3 dropped an item while blocked");

  a_clip_at_rail: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.clipped |->
      (rsp.out_x == VMAX || rsp.out_x == VMIN || rsp.out_y == VMAX ||
       rsp.out_y == VMIN || rsp.out_z == VMAX || rsp.out_z == VMIN))
    else $error("clipped set with no component at a rail");
`endif

endmodule

`default_nettype wire
